[rtl/erp_pkg.sv]
// ----------------------------------------------------------------------------
// erp_pkg
// Types, codes and the per-character lexing and record grammar step.
// ----------------------------------------------------------------------------
package erp_pkg;

   localparam int MAX_SKIP_DEPTH  = 255;
   localparam int LINE_COUNT_BITS = 16;
   localparam int SKIP_W          = $clog2(MAX_SKIP_DEPTH + 1);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_LBRK  = 8'h5b;
   localparam logic [7:0] CH_RBRK  = 8'h5d;
   localparam logic [7:0] CH_LBRC  = 8'h7b;
   localparam logic [7:0] CH_RBRC  = 8'h7d;

   localparam logic [30:0] ID_MAX = 31'h7fffffff;

   typedef enum logic [2:0] {
      KIND_EVENT_ID = 3'd0,
      KIND_PRED_ID  = 3'd1,
      KIND_ICNF_ID  = 3'd2,
      KIND_DONE     = 3'd3,
      KIND_ERROR    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ERR_EARLY_END = 3'd0,
      ERR_QUOTE     = 3'd1,
      ERR_BAD_TOKEN = 3'd2,
      ERR_TOO_BIG   = 3'd3,
      ERR_TOO_DEEP  = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      LX_GAP, LX_IDENT, LX_INT, LX_STRING
   } lex_type;

   typedef enum logic [2:0] {
      TK_LP, TK_RP, TK_EQ, TK_COMMA, TK_IDENT, TK_STRING, TK_INT
   } tok_type;

   typedef enum logic [3:0] {
      G_OPEN, G_ID, G_COMMA1, G_EVENT, G_LISTS_OPEN, G_ATTR_FIRST, G_ATTR_NAME,
      G_EQ, G_IDS_OPEN, G_IDS, G_IDS_INT, G_SKIP_FIRST, G_SKIP, G_CLOSE, G_DONE,
      G_ATTR_NEXT
   } gpos_type;

   typedef enum logic [1:0] {
      AK_NONE, AK_PRED, AK_ICNF, AK_OTHER
   } akind_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [30:0] value;
      logic [2:0]  error_code;
      logic [15:0] line_number;
      logic        last;
   } rsp_type;

   typedef struct packed {
      lex_type                    lex;
      gpos_type                   gpos;
      logic [30:0]                accum;
      logic                       too_big;
      logic [2:0]                 kw;
      logic [2:0]                 ilen;
      akind_type                  akind;
      logic                       first;
      logic [SKIP_W-1:0]          skip;
      logic [LINE_COUNT_BITS-1:0] line_count;
      logic                       err;
   } state_type;

   typedef struct packed {
      state_type    st;
      rsp_type [1:0] res;
      logic [1:0]   cnt;
   } ctx_type;

   localparam state_type STATE_RESET = '{
      lex: LX_GAP, gpos: G_OPEN, accum: '0, too_big: 1'b0, kw: 3'b111,
      ilen: '0, akind: AK_NONE, first: 1'b1, skip: '0, line_count: '0,
      err: 1'b0};

   function automatic logic [7:0] kw_event_ch(logic [2:0] p);
      case (p)
         3'd0: kw_event_ch = 8'h45;
         3'd1: kw_event_ch = 8'h76;
         3'd2: kw_event_ch = 8'h65;
         3'd3: kw_event_ch = 8'h6e;
         3'd4: kw_event_ch = 8'h74;
         default: kw_event_ch = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] kw_pred_ch(logic [2:0] p);
      case (p)
         3'd0: kw_pred_ch = 8'h70;
         3'd1: kw_pred_ch = 8'h72;
         3'd2: kw_pred_ch = 8'h65;
         3'd3: kw_pred_ch = 8'h64;
         default: kw_pred_ch = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] kw_icnf_ch(logic [2:0] p);
      case (p)
         3'd0: kw_icnf_ch = 8'h69;
         3'd1: kw_icnf_ch = 8'h63;
         3'd2: kw_icnf_ch = 8'h6e;
         3'd3: kw_icnf_ch = 8'h66;
         default: kw_icnf_ch = 8'h00;
      endcase
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic ends_ident(logic [7:0] c);
      ends_ident = c == CH_SPACE || c == CH_LPAR || c == CH_LBRC || c == CH_LBRK ||
                   c == CH_RPAR || c == CH_RBRC || c == CH_RBRK || c == CH_EQ ||
                   c == CH_COMMA || c == CH_QUOTE;
   endfunction

   function automatic ctx_type f_emit(ctx_type c, kind_type k, logic [30:0] v,
                                      err_type e);
      logic [LINE_COUNT_BITS-1:0] lc1;
      ctx_type r;
      r = c;
      lc1 = c.st.line_count + LINE_COUNT_BITS'(1);
      if (c.cnt < 2'd2) begin
         r.res[c.cnt[0]].kind        = k;
         r.res[c.cnt[0]].value       = v;
         r.res[c.cnt[0]].error_code  = e;
         r.res[c.cnt[0]].line_number = 16'(lc1);
         r.res[c.cnt[0]].last        = 1'b0;
         r.cnt = c.cnt + 2'd1;
      end
      return r;
   endfunction

   function automatic ctx_type f_fail(ctx_type c, err_type e);
      ctx_type r;
      r = f_emit(c, KIND_ERROR, '0, e);
      r.st.err = 1'b1;
      return r;
   endfunction

   function automatic ctx_type f_take_id(ctx_type c, kind_type k);
      ctx_type r;
      if (c.st.too_big) r = f_fail(c, ERR_TOO_BIG);
      else r = f_emit(c, k, c.st.accum, ERR_EARLY_END);
      return r;
   endfunction

   function automatic ctx_type f_match(ctx_type c, logic [7:0] ch);
      ctx_type r;
      logic [2:0] p;
      r = c;
      p = c.st.ilen;
      if (p >= 3'd5 || ch != kw_event_ch(p)) r.st.kw[0] = 1'b0;
      if (p >= 3'd4 || ch != kw_pred_ch(p))  r.st.kw[1] = 1'b0;
      if (p >= 3'd4 || ch != kw_icnf_ch(p))  r.st.kw[2] = 1'b0;
      if (p < 3'd7) r.st.ilen = p + 3'd1;
      return r;
   endfunction

   function automatic ctx_type f_token(ctx_type c, tok_type t);
      ctx_type r;
      logic is_event;
      logic is_pred;
      logic is_icnf;
      kind_type lk;
      logic [SKIP_W-1:0] sd;
      r = c;
      is_event = c.st.kw[0] && c.st.ilen == 3'd5;
      is_pred  = c.st.kw[1] && c.st.ilen == 3'd4;
      is_icnf  = c.st.kw[2] && c.st.ilen == 3'd4;
      lk = (c.st.akind == AK_ICNF) ? KIND_ICNF_ID : KIND_PRED_ID;
      case (c.st.gpos)
         G_OPEN: begin
            if (t == TK_LP) r.st.gpos = G_ID; else r = f_fail(c, ERR_BAD_TOKEN);
         end
         G_ID: begin
            if (t != TK_INT) r = f_fail(c, ERR_BAD_TOKEN);
            else begin
               r = f_take_id(c, KIND_EVENT_ID);
               r.st.gpos = G_COMMA1;
            end
         end
         G_COMMA1: begin
            if (t == TK_COMMA) r.st.gpos = G_EVENT; else r = f_fail(c, ERR_BAD_TOKEN);
         end
         G_EVENT: begin
            if (t == TK_IDENT && is_event) r.st.gpos = G_LISTS_OPEN;
            else r = f_fail(c, ERR_BAD_TOKEN);
         end
         G_LISTS_OPEN: begin
            if (t == TK_LP) r.st.gpos = G_ATTR_FIRST; else r = f_fail(c, ERR_BAD_TOKEN);
         end
         G_ATTR_FIRST, G_ATTR_NAME: begin
            if (t == TK_RP && c.st.gpos == G_ATTR_FIRST) r.st.gpos = G_CLOSE;
            else if (t == TK_IDENT) begin
               r.st.akind = is_pred ? AK_PRED : (is_icnf ? AK_ICNF : AK_OTHER);
               r.st.gpos = G_EQ;
            end else r = f_fail(c, ERR_BAD_TOKEN);
         end
         G_ATTR_NEXT: begin
            if (t == TK_RP) r.st.gpos = G_CLOSE;
            else if (t == TK_COMMA) r.st.gpos = G_ATTR_NAME;
            else r = f_fail(c, ERR_BAD_TOKEN);
         end
         G_EQ: begin
            if (t != TK_EQ) r = f_fail(c, ERR_BAD_TOKEN);
            else if (c.st.akind == AK_PRED || c.st.akind == AK_ICNF)
               r.st.gpos = G_IDS_OPEN;
            else r.st.gpos = G_SKIP_FIRST;
         end
         G_IDS_OPEN: begin
            if (t == TK_LP) begin
               r.st.gpos = G_IDS;
               r.st.first = 1'b1;
            end else r = f_fail(c, ERR_BAD_TOKEN);
         end
         G_IDS: begin
            if (t == TK_RP) r.st.gpos = G_ATTR_NEXT;
            else if (c.st.first) begin
               if (t == TK_INT) begin
                  r = f_take_id(c, lk);
                  r.st.first = 1'b0;
               end else r = f_fail(c, ERR_BAD_TOKEN);
            end else if (t == TK_COMMA) r.st.gpos = G_IDS_INT;
            else r = f_fail(c, ERR_BAD_TOKEN);
         end
         G_IDS_INT: begin
            if (t == TK_INT) begin
               r = f_take_id(c, lk);
               r.st.gpos = G_IDS;
            end else r = f_fail(c, ERR_BAD_TOKEN);
         end
         G_SKIP_FIRST: begin
            if (t == TK_LP) begin
               if (c.st.skip >= SKIP_W'(MAX_SKIP_DEPTH)) r = f_fail(c, ERR_TOO_DEEP);
               else begin
                  r.st.skip = SKIP_W'(1);
                  r.st.gpos = G_SKIP;
               end
            end else r.st.gpos = G_ATTR_NEXT;
         end
         G_SKIP: begin
            if (t == TK_LP) begin
               if (c.st.skip >= SKIP_W'(MAX_SKIP_DEPTH)) r = f_fail(c, ERR_TOO_DEEP);
               else r.st.skip = c.st.skip + SKIP_W'(1);
            end else if (t == TK_RP) begin
               sd = c.st.skip;
               if (sd != '0) sd = sd - SKIP_W'(1);
               r.st.skip = sd;
               if (sd == '0) r.st.gpos = G_ATTR_NEXT;
            end
         end
         G_CLOSE: begin
            if (t == TK_RP) begin
               r = f_emit(c, KIND_DONE, '0, ERR_EARLY_END);
               r.st.gpos = G_DONE;
            end else r = f_fail(c, ERR_BAD_TOKEN);
         end
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic ctx_type f_char(ctx_type c, logic [7:0] ch);
      ctx_type r;
      logic done;
      logic [34:0] prod;
      r = c;
      done = 1'b0;
      prod = 35'(c.st.accum) * 35'd10 + 35'(ch - CH_ZERO);
      if (c.st.lex == LX_STRING) begin
         done = 1'b1;
         if (ch == CH_QUOTE) begin
            r.st.lex = LX_GAP;
            r = f_token(r, TK_STRING);
         end
      end else if (c.st.lex == LX_IDENT) begin
         if (!ends_ident(ch)) begin
            r = f_match(r, ch);
            done = 1'b1;
         end else begin
            r.st.lex = LX_GAP;
            r = f_token(r, TK_IDENT);
         end
      end else if (c.st.lex == LX_INT) begin
         if (is_digit(ch)) begin
            if (prod > 35'(ID_MAX)) r.st.too_big = 1'b1;
            else r.st.accum = prod[30:0];
            done = 1'b1;
         end else begin
            r.st.lex = LX_GAP;
            r = f_token(r, TK_INT);
         end
      end
      if (!done && !r.st.err && r.st.gpos != G_DONE) begin
         if (ch == CH_SPACE) r = r;
         else if (ch == CH_LPAR || ch == CH_LBRC || ch == CH_LBRK) r = f_token(r, TK_LP);
         else if (ch == CH_RPAR || ch == CH_RBRC || ch == CH_RBRK) r = f_token(r, TK_RP);
         else if (ch == CH_EQ) r = f_token(r, TK_EQ);
         else if (ch == CH_COMMA) r = f_token(r, TK_COMMA);
         else if (ch == CH_QUOTE) r.st.lex = LX_STRING;
         else if (is_digit(ch)) begin
            r.st.lex = LX_INT;
            r.st.accum = 31'(ch - CH_ZERO);
            r.st.too_big = 1'b0;
         end else begin
            r.st.lex = LX_IDENT;
            r.st.ilen = '0;
            r.st.kw = 3'b111;
            r = f_match(r, ch);
         end
      end
      return r;
   endfunction

   function automatic ctx_type f_line_end(ctx_type c);
      ctx_type r;
      r = c;
      if (c.st.gpos != G_DONE) begin
         if (c.st.lex == LX_IDENT) r = f_token(r, TK_IDENT);
         else if (c.st.lex == LX_INT) r = f_token(r, TK_INT);
         else if (c.st.lex == LX_STRING) r = f_fail(r, ERR_QUOTE);
         if (!r.st.err && r.st.gpos != G_DONE) r = f_fail(r, ERR_EARLY_END);
      end
      if (!r.st.err) begin
         r.st.line_count = r.st.line_count + LINE_COUNT_BITS'(1);
         r.st.gpos = G_OPEN;
         r.st.lex = LX_GAP;
      end
      return r;
   endfunction

endpackage

[rtl/erp_step.sv]
// ----------------------------------------------------------------------------
// erp_step
// One character or line end: next parser state and up to two results.
// ----------------------------------------------------------------------------
module erp_step import erp_pkg::*; (
   input  state_type     state,
   input  req_type       req,
   output state_type     state_next,
   output rsp_type [1:0] res,
   output logic [1:0]    res_cnt
);

   ctx_type c0;
   ctx_type c1;

   always_comb begin
      c0.st  = state;
      c0.res = '0;
      c0.cnt = 2'd0;
      c1 = c0;
      if (!state.err) begin
         if (req.line_end) c1 = f_line_end(c0);
         else if (state.gpos != G_DONE) c1 = f_char(c0, req.ch);
      end
      if (c1.cnt == 2'd1) c1.res[0].last = 1'b1;
      if (c1.cnt == 2'd2) c1.res[1].last = 1'b1;
      state_next = c1.st;
      res        = c1.res;
      res_cnt    = c1.cnt;
   end

endmodule

[rtl/erp_queue.sv]
// ----------------------------------------------------------------------------
// erp_queue
// Four-entry result queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module erp_queue import erp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  rsp_type [1:0] wr_data,
   input  logic [1:0]    wr_cnt,
   output logic [2:0]    count,
   output logic          rd_valid,
   input  logic          rd_take,
   output rsp_type       rd_data
);

   rsp_type [3:0] mem_ff;
   logic [1:0]    wr_ptr_ff, wr_ptr_in;
   logic [1:0]    rd_ptr_ff, rd_ptr_in;
   logic [2:0]    count_ff, count_in;
   logic          pop;

   assign pop      = rd_take && (count_ff != 3'd0);
   assign rd_valid = count_ff != 3'd0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + wr_cnt;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, wr_cnt} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cnt != 2'd0) mem_ff[wr_ptr_ff] <= wr_data[0];
      if (wr_cnt == 2'd2) mem_ff[wr_ptr_ff + 2'd1] <= wr_data[1];
   end

endmodule

[rtl/event_record_text_parser_top.sv]
// ----------------------------------------------------------------------------
// event_record_text_parser_top
// Event record line parser: characters in, ids, done and error results out.
//
//   channel  dir  payload   handshake
//   req      in   req_type  req_valid / req_stall
//   rsp      out  rsp_type  rsp_valid / rsp_stall
//
// One request per cycle while req is not stalled: input register, one
// combinational parse step, then a four-entry result queue. A request gives
// zero to two results, which leave one at a time on rsp.
// Synchronous reset clears parser state and the queue. req stalls while the
// queue cannot take two more results.
// ----------------------------------------------------------------------------
module event_record_text_parser_top import erp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic          in_vld_ff, in_vld_in;
   req_type       in_ff;
   state_type     state_ff, state_in;
   state_type     state_next;
   rsp_type [1:0] res;
   logic [1:0]    res_cnt;
   logic [1:0]    wr_cnt;
   logic [2:0]    q_count;
   logic          advance;

   assign advance   = in_vld_ff && (q_count <= 3'd2);
   assign req_stall = in_vld_ff && !advance;
   assign wr_cnt    = advance ? res_cnt : 2'd0;

   always_comb begin
      in_vld_in = req_stall ? in_vld_ff : req_valid;
      state_in  = advance ? state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         state_ff  <= STATE_RESET;
      end else begin
         in_vld_ff <= in_vld_in;
         state_ff  <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_ff <= req_data;
   end

   erp_step u_step (
      .state      (state_ff),
      .req        (in_ff),
      .state_next (state_next),
      .res        (res),
      .res_cnt    (res_cnt)
   );

   erp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_data  (res),
      .wr_cnt   (wr_cnt),
      .count    (q_count),
      .rd_valid (rsp_valid),
      .rd_take  (!rsp_stall),
      .rd_data  (rsp_data)
   );

endmodule
